### rtl/token_classifier_lexer_defines.svh
// Assertion macros used by the lexer RTL.
`ifndef TOKEN_CLASSIFIER_LEXER_DEFINES_SVH
`define TOKEN_CLASSIFIER_LEXER_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define TCL_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("lexer check failed: same-cycle implication");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define TCL_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("lexer check failed: next-cycle implication");

`endif

### rtl/tcl_pkg.sv
// Types, constants and character tables for the token classifier lexer.
package tcl_pkg;

   // Default parameter values.
   localparam int MAX_TOKEN_LEN_DEF = 31;
   localparam int COUNT_WIDTH_DEF   = 16;

   // Fixed field widths of the result item.
   localparam int TOKEN_NUM_W = 16;
   localparam int CLASS_W     = 3;
   localparam int CHAR_W      = 8;
   localparam int KW_IDX_W    = 3;
   localparam int TOKEN_LEN_W = 5;

   // Packed port widths (tdata padded to whole bytes).
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_FIELD_W = TOKEN_NUM_W + CHAR_W + KW_IDX_W + TOKEN_LEN_W + 1;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_TUSER_W = CLASS_W;

   // Keyword table.
   localparam int NUM_KEYWORDS = 5;
   localparam int KW_MAXLEN    = 5;

   localparam logic [CHAR_W-1:0] KW_TEXT [NUM_KEYWORDS][KW_MAXLEN] = '{
      '{8'h76, 8'h6F, 8'h69, 8'h64, 8'h00},   // void
      '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00},   // if
      '{8'h77, 8'h68, 8'h69, 8'h6C, 8'h65},   // while
      '{8'h69, 8'h6E, 8'h74, 8'h00, 8'h00},   // int
      '{8'h6D, 8'h61, 8'h69, 8'h6E, 8'h00}    // main
   };
   localparam logic [2:0] KW_LEN [NUM_KEYWORDS] = '{3'd4, 3'd2, 3'd5, 3'd3, 3'd4};

   // Token class codes.
   localparam logic [CLASS_W-1:0] CLASS_SPECIAL    = 3'd0;
   localparam logic [CLASS_W-1:0] CLASS_MULTIPLY   = 3'd1;
   localparam logic [CLASS_W-1:0] CLASS_ASSIGN     = 3'd2;
   localparam logic [CLASS_W-1:0] CLASS_ADD        = 3'd3;
   localparam logic [CLASS_W-1:0] CLASS_PREPROC    = 3'd4;
   localparam logic [CLASS_W-1:0] CLASS_KEYWORD    = 3'd5;
   localparam logic [CLASS_W-1:0] CLASS_IDENTIFIER = 3'd6;
   localparam logic [CLASS_W-1:0] CLASS_NUMBER     = 3'd7;

   // Single-character symbols.
   localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
   localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
   localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
   localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
   localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
   localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_EQUAL  = 8'h3D;
   localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;

   // Scanner mode.
   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_NUMBER
   } mode_type;

   // Symbol lookup result.
   typedef struct packed {
      logic               hit;
      logic [CLASS_W-1:0] cls;
   } sym_type;

   // One result item as held in the output queue.
   typedef struct packed {
      logic [TOKEN_NUM_W-1:0] token_number;
      logic [CLASS_W-1:0]     token_class;
      logic [CHAR_W-1:0]      symbol;
      logic [KW_IDX_W-1:0]    keyword_index;
      logic [TOKEN_LEN_W-1:0] token_length;
      logic                   truncated;
      logic                   last_result;
   } rsp_item_type;

   // Classify a character as one of the single-character tokens.
   function automatic sym_type sym_lookup(input logic [CHAR_W-1:0] c);
      sym_type s;
      s.hit = 1'b1;
      s.cls = CLASS_SPECIAL;
      case (c)
         CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_SEMI: s.cls = CLASS_SPECIAL;
         CH_STAR:  s.cls = CLASS_MULTIPLY;
         CH_EQUAL: s.cls = CLASS_ASSIGN;
         CH_PLUS:  s.cls = CLASS_ADD;
         CH_HASH:  s.cls = CLASS_PREPROC;
         default:  s.hit = 1'b0;
      endcase
      return s;
   endfunction

   function automatic logic is_letter(input logic [CHAR_W-1:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   // Keywords whose character at position pos equals c.
   function automatic logic [NUM_KEYWORDS-1:0] kw_pos_match(input logic [2:0] pos,
                                                            input logic [CHAR_W-1:0] c);
      logic [NUM_KEYWORDS-1:0] m;
      m = '0;
      for (int k = 0; k < NUM_KEYWORDS; k++) begin
         if (pos < KW_LEN[k]) begin
            m[k] = (KW_TEXT[k][pos] == c);
         end
      end
      return m;
   endfunction

endpackage

### rtl/token_classifier_lexer.sv
// Top level of the token classifier lexer: scanner state, classification and result queue.
//
// Usage: one source character is sent per request on the req_ channel (tdata holds
// the byte, tlast flags end of input and flushes a pending word; the byte is then
// ignored). Tokens leave on the rsp_ channel, one per transfer; rsp_tlast marks the
// last token caused by a request. A request causes zero, one or two tokens.
// Each token is written into the queue when its request is accepted and is presented on
// rsp_ once the tokens ahead of it have left. Throughput: one character per cycle while
// req_tready is high. Scanner state updates in the accepting cycle, so the next character
// may follow at once. Tokens go into a four-entry queue that drains one token per cycle
// while rsp_tready is high; req_tready is high while at least two entries are free.
// Stall: when the receiver holds rsp_tready low, the queue fills and req_tready
// drops; nothing is lost and the token at the head stays steady.
// Reset (synchronous, active high): the scanner goes idle with no word pending, the
// token counter restarts at one and the queue empties. No clearing pass is needed.
`include "token_classifier_lexer_defines.svh"

module token_classifier_lexer #(
   parameter int MAX_TOKEN_LEN = tcl_pkg::MAX_TOKEN_LEN_DEF,
   parameter int COUNT_WIDTH   = tcl_pkg::COUNT_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tcl_pkg::REQ_TDATA_W-1:0] req_tdata,  // [7:0] char_in
   input  logic                            req_tlast,  // end_of_input
   // Result channel.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [15:0] token_number, [23:16] symbol, [26:24] keyword_index,
   // [31:27] token_length, [32] truncated, [39:33] zero
   output logic [tcl_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [tcl_pkg::RSP_TUSER_W-1:0] rsp_tuser,  // [2:0] token_class
   output logic                            rsp_tlast   // last_result
);

   localparam int LEN_W      = $clog2(MAX_TOKEN_LEN + 1);
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   // Scanner state.
   tcl_pkg::mode_type                    mode_ff, mode_in;
   logic [COUNT_WIDTH-1:0]               token_counter_ff, token_counter_in;
   logic [LEN_W-1:0]                     word_length_ff, word_length_in;
   logic [tcl_pkg::NUM_KEYWORDS-1:0]     kw_mask_ff, kw_mask_in;
   logic                                 overflow_ff, overflow_in;

   // Result queue.
   tcl_pkg::rsp_item_type                fifo_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]                     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]                     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]                     fifo_count_ff, fifo_count_in;

   // Per-request decode.
   logic                                 req_fire, rsp_fire;
   logic [tcl_pkg::CHAR_W-1:0]           c;
   logic                                 eoi, letter, digit;
   tcl_pkg::sym_type                     sym;
   logic                                 word_cont, flush_now, classify_now;
   logic                                 has_sym, start_ident, start_number;
   logic                                 grow_now, kw_found;
   logic [tcl_pkg::KW_IDX_W-1:0]         kw_idx;
   logic [LEN_W-1:0]                     grow_len;
   logic [tcl_pkg::NUM_KEYWORDS-1:0]     grow_mask;
   logic                                 grow_ovf;
   logic [COUNT_WIDTH-1:0]               sym_count;
   tcl_pkg::rsp_item_type                word_item, sym_item, push0, push1;
   logic [1:0]                           n_push;

   assign req_tready = (fifo_count_ff <= CNT_W'(FIFO_DEPTH - 2));
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = (fifo_count_ff != '0);
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   assign c      = req_tdata[tcl_pkg::CHAR_W-1:0];
   assign eoi    = req_tlast;
   assign letter = tcl_pkg::is_letter(c);
   assign digit  = tcl_pkg::is_digit(c);
   assign sym    = tcl_pkg::sym_lookup(c);

   // Decide whether the character continues, ends or starts a word.
   always_comb begin
      word_cont = 1'b0;
      case (mode_ff)
         tcl_pkg::MODE_IDENT:  word_cont = letter || digit;
         tcl_pkg::MODE_NUMBER: word_cont = digit;
         default:              word_cont = 1'b0;
      endcase
      flush_now    = (mode_ff != tcl_pkg::MODE_IDLE) && (eoi || !word_cont);
      grow_now     = !eoi && word_cont;
      classify_now = !eoi && !word_cont;
      has_sym      = classify_now && sym.hit;
      start_ident  = classify_now && !sym.hit && letter;
      start_number = classify_now && !sym.hit && digit && !letter;
   end

   // Extend the word by one character: per-position keyword match and length count.
   always_comb begin
      logic [LEN_W-1:0] base_len;
      logic [tcl_pkg::NUM_KEYWORDS-1:0] base_mask;
      logic base_ovf;
      base_len  = grow_now ? word_length_ff : '0;
      base_mask = grow_now ? kw_mask_ff : '1;
      base_ovf  = grow_now ? overflow_ff : 1'b0;
      grow_len  = base_len;
      grow_mask = base_mask;
      grow_ovf  = base_ovf;
      if (base_len >= LEN_W'(MAX_TOKEN_LEN)) begin
         grow_ovf = 1'b1;
      end else begin
         if (base_len < LEN_W'(tcl_pkg::KW_MAXLEN)) begin
            grow_mask = base_mask & tcl_pkg::kw_pos_match(base_len[2:0], c);
         end else begin
            grow_mask = '0;
         end
         grow_len = base_len + LEN_W'(1);
      end
   end

   // Keyword check on the pending word: first keyword still matching at full length, none if truncated.
   always_comb begin
      kw_found = 1'b0;
      kw_idx   = '0;
      for (int j = 0; j < tcl_pkg::NUM_KEYWORDS; j++) begin
         if (!kw_found && kw_mask_ff[j] && (word_length_ff == LEN_W'(tcl_pkg::KW_LEN[j]))) begin
            kw_found = 1'b1;
            kw_idx   = tcl_pkg::KW_IDX_W'(j);
         end
      end
      if (overflow_ff) begin
         kw_found = 1'b0;
         kw_idx   = '0;
      end
   end

   // Build the word token and the symbol token, then order them for the queue.
   always_comb begin
      word_item.token_number  = tcl_pkg::TOKEN_NUM_W'(token_counter_ff);
      word_item.token_class   = (mode_ff == tcl_pkg::MODE_NUMBER) ? tcl_pkg::CLASS_NUMBER :
                                kw_found ? tcl_pkg::CLASS_KEYWORD : tcl_pkg::CLASS_IDENTIFIER;
      word_item.symbol        = '0;
      word_item.keyword_index = (mode_ff == tcl_pkg::MODE_NUMBER) ? '0 : kw_idx;
      word_item.token_length  = tcl_pkg::TOKEN_LEN_W'(word_length_ff);
      word_item.truncated     = overflow_ff;
      word_item.last_result   = !has_sym;

      // The symbol follows the flushed word, wrapping at the counter width.
      sym_count               = token_counter_ff + COUNT_WIDTH'(flush_now);
      sym_item.token_number   = tcl_pkg::TOKEN_NUM_W'(sym_count);
      sym_item.token_class    = sym.cls;
      sym_item.symbol         = c;
      sym_item.keyword_index  = '0;
      sym_item.token_length   = tcl_pkg::TOKEN_LEN_W'(1);
      sym_item.truncated      = 1'b0;
      sym_item.last_result    = 1'b1;

      push0  = flush_now ? word_item : sym_item;
      push1  = sym_item;
      n_push = req_fire ? (2'(flush_now) + 2'(has_sym)) : 2'd0;
   end

   // Next scanner state.
   always_comb begin
      mode_in          = mode_ff;
      word_length_in   = word_length_ff;
      kw_mask_in       = kw_mask_ff;
      overflow_in      = overflow_ff;
      token_counter_in = token_counter_ff + COUNT_WIDTH'(n_push);
      if (req_fire) begin
         if (grow_now || start_ident || start_number) begin
            word_length_in = grow_len;
            kw_mask_in     = grow_mask;
            overflow_in    = grow_ovf;
            if (start_ident) begin
               mode_in = tcl_pkg::MODE_IDENT;
            end else if (start_number) begin
               mode_in = tcl_pkg::MODE_NUMBER;
            end
         end else if (flush_now) begin
            mode_in        = tcl_pkg::MODE_IDLE;
            word_length_in = '0;
            kw_mask_in     = '1;
            overflow_in    = 1'b0;
         end
      end
   end

   // Queue pointers and fill level.
   always_comb begin
      wr_ptr_in     = wr_ptr_ff + PTR_W'(n_push);
      rd_ptr_in     = rd_ptr_ff + PTR_W'(rsp_fire);
      fifo_count_in = fifo_count_ff + CNT_W'(n_push) - CNT_W'(rsp_fire);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= tcl_pkg::MODE_IDLE;
         token_counter_ff <= COUNT_WIDTH'(1);
         word_length_ff   <= '0;
         kw_mask_ff       <= '1;
         overflow_ff      <= 1'b0;
         wr_ptr_ff        <= '0;
         rd_ptr_ff        <= '0;
         fifo_count_ff    <= '0;
      end else begin
         mode_ff          <= mode_in;
         token_counter_ff <= token_counter_in;
         word_length_ff   <= word_length_in;
         kw_mask_ff       <= kw_mask_in;
         overflow_ff      <= overflow_in;
         wr_ptr_ff        <= wr_ptr_in;
         rd_ptr_ff        <= rd_ptr_in;
         fifo_count_ff    <= fifo_count_in;
      end
   end

   // Queue storage: up to two tokens written per cycle.
   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= push0;
      end
      if (n_push == 2'd2) begin
         fifo_ff[wr_ptr_ff + PTR_W'(1)] <= push1;
      end
   end

   // Head of the queue onto the result ports.
   always_comb begin
      tcl_pkg::rsp_item_type head;
      head      = fifo_ff[rd_ptr_ff];
      rsp_tdata = tcl_pkg::RSP_TDATA_W'({head.truncated, head.token_length,
                                         head.keyword_index, head.symbol,
                                         head.token_number});
      rsp_tuser = head.token_class;
      rsp_tlast = head.last_result;
   end

   // Checks.
   `TCL_ASSERT_NOW(a_fifo_bound, clock, reset, 1'b1, fifo_count_ff <= CNT_W'(FIFO_DEPTH))
   `TCL_ASSERT_NOW(a_accept_room, clock, reset, req_fire,
                   fifo_count_ff <= CNT_W'(FIFO_DEPTH - 2))
   `TCL_ASSERT_NOW(a_word_nonempty, clock, reset, mode_ff != tcl_pkg::MODE_IDLE,
                   word_length_ff != '0)
   `TCL_ASSERT_NEXT(a_eoi_idle, clock, reset, req_fire && req_tlast,
                    mode_ff == tcl_pkg::MODE_IDLE)

endmodule
